### rtl/ste_pkg.sv
// Shared types, codes and register map of the schedule trigger evaluator.
package ste_pkg;

  localparam int unsigned MinuteW    = 11;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned SensorW    = 32;
  localparam int unsigned RepeatW    = 24;
  localparam int unsigned FlagsW     = 5;
  localparam int unsigned WdayMaskW  = 7;
  localparam int unsigned WdayW      = 3;
  localparam int unsigned PaddrW     = 5;
  localparam int unsigned PdataW     = 32;
  localparam int unsigned RegIdxW    = 3;

  localparam logic [1:0] MODE_CHECK  = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] CMP_GT = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_EQ = 2'd2;

  localparam int unsigned FLAG_EXACT   = 0;
  localparam int unsigned FLAG_WINDOW  = 1;
  localparam int unsigned FLAG_WEEKDAY = 2;
  localparam int unsigned FLAG_SENSOR  = 3;
  localparam int unsigned FLAG_ACTIVE  = 4;

  localparam logic [RegIdxW-1:0] REG_CONTROL   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_EXACT     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_WIN_START = 3'd2;
  localparam logic [RegIdxW-1:0] REG_WIN_END   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_WDAY_MASK = 3'd4;
  localparam logic [RegIdxW-1:0] REG_COMPARE   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_THRESHOLD = 3'd6;
  localparam logic [RegIdxW-1:0] REG_REPEAT    = 3'd7;

  typedef struct packed {
    logic [FlagsW-1:0]        control_flags;
    logic [MinuteW-1:0]       exact_minute;
    logic [MinuteW-1:0]       window_start;
    logic [MinuteW-1:0]       window_end;
    logic [WdayMaskW-1:0]     weekday_mask;
    logic [1:0]               sensor_compare;
    logic signed [SensorW-1:0] sensor_threshold;
    logic [RepeatW-1:0]       refire_period;
  } ste_cfg_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic [TimeW-1:0]          now_seconds;
    logic [MinuteW-1:0]        minute_of_day;
    logic [WdayW-1:0]          weekday;
    logic signed [SensorW-1:0] sensor_reading;
    logic                      sensor_valid;
  } ste_tick_t;

endpackage

### rtl/ste_cfg_regs.sv
// APB configuration register file of the schedule trigger evaluator.
module ste_cfg_regs import ste_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output ste_cfg_t          cfg_o
);

  ste_cfg_t             cfg_q;
  logic                 wr_en;
  logic [RegIdxW-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PaddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CONTROL:   cfg_q.control_flags    <= pwdata[FlagsW-1:0];
        REG_EXACT:     cfg_q.exact_minute     <= pwdata[MinuteW-1:0];
        REG_WIN_START: cfg_q.window_start     <= pwdata[MinuteW-1:0];
        REG_WIN_END:   cfg_q.window_end       <= pwdata[MinuteW-1:0];
        REG_WDAY_MASK: cfg_q.weekday_mask     <= pwdata[WdayMaskW-1:0];
        REG_COMPARE:   cfg_q.sensor_compare   <= pwdata[1:0];
        REG_THRESHOLD: cfg_q.sensor_threshold <= $signed(pwdata[SensorW-1:0]);
        REG_REPEAT:    cfg_q.refire_period    <= pwdata[RepeatW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_CONTROL:   prdata[FlagsW-1:0]    = cfg_q.control_flags;
      REG_EXACT:     prdata[MinuteW-1:0]   = cfg_q.exact_minute;
      REG_WIN_START: prdata[MinuteW-1:0]   = cfg_q.window_start;
      REG_WIN_END:   prdata[MinuteW-1:0]   = cfg_q.window_end;
      REG_WDAY_MASK: prdata[WdayMaskW-1:0] = cfg_q.weekday_mask;
      REG_COMPARE:   prdata[1:0]           = cfg_q.sensor_compare;
      REG_THRESHOLD: prdata[SensorW-1:0]   = cfg_q.sensor_threshold;
      REG_REPEAT:    prdata[RepeatW-1:0]   = cfg_q.refire_period;
      default:       prdata = '0;
    endcase
  end

endmodule

### rtl/ste_cond_match.sv
// Condition matcher: ANDs the enabled minute, window, weekday and sensor tests; no match when none is enabled.
module ste_cond_match import ste_pkg::*; (
  input  ste_cfg_t  cfg_i,
  input  ste_tick_t tick_i,
  output logic      match_o
);

  logic [3:0]            enables;
  logic                  exact_ok;
  logic                  window_ok;
  logic                  wday_ok;
  logic                  sensor_ok;
  logic                  cmp_ok;
  logic [WdayMaskW:0]    wday_bits;

  assign enables = cfg_i.control_flags[FLAG_SENSOR:FLAG_EXACT];
  assign exact_ok = tick_i.minute_of_day == cfg_i.exact_minute;

  always_comb begin
    if (cfg_i.window_start < cfg_i.window_end) begin
      window_ok = (tick_i.minute_of_day >= cfg_i.window_start) &&
                  (tick_i.minute_of_day <  cfg_i.window_end);
    end else begin
      window_ok = (tick_i.minute_of_day >= cfg_i.window_start) ||
                  (tick_i.minute_of_day <  cfg_i.window_end);
    end
  end

  assign wday_bits = {1'b0, cfg_i.weekday_mask};
  assign wday_ok   = wday_bits[tick_i.weekday];

  always_comb begin
    case (cfg_i.sensor_compare)
      CMP_GT:  cmp_ok = tick_i.sensor_reading >  cfg_i.sensor_threshold;
      CMP_LT:  cmp_ok = tick_i.sensor_reading <  cfg_i.sensor_threshold;
      CMP_EQ:  cmp_ok = tick_i.sensor_reading == cfg_i.sensor_threshold;
      default: cmp_ok = 1'b0;
    endcase
  end

  assign sensor_ok = tick_i.sensor_valid & cmp_ok;

  assign match_o = (enables != 4'd0)
                 && (!enables[FLAG_EXACT]   || exact_ok)
                 && (!enables[FLAG_WINDOW]  || window_ok)
                 && (!enables[FLAG_WEEKDAY] || wday_ok)
                 && (!enables[FLAG_SENSOR]  || sensor_ok);

endmodule

### rtl/schedule_trigger_evaluator.sv
// Top level of the schedule trigger evaluator: tick register, trigger state, result register.
//
//   channel | direction | handshake               | payload
//   tick    | in        | in_valid_i / in_stall_o  | mode, now_seconds, minute_of_day,
//           |           |                          | weekday, sensor_reading, sensor_valid
//   result  | out       | out_valid_o / out_stall_i| fire, conditions_met, armed
//   config  | in        | APB psel/penable/pwrite  | eight registers at 4*i
//
// One word per cycle sustained while the result side is not stalled; a tick passes
// through the tick register and the single evaluate-and-update path into the result register.
// Reset clears configuration, the fired flag, last fire time and both valid bits.
// A stalled result holds; the tick register keeps filling until both stages are full.
module schedule_trigger_evaluator import ste_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                mode_i,
  input  logic [TimeW-1:0]          now_seconds_i,
  input  logic [MinuteW-1:0]        minute_of_day_i,
  input  logic [WdayW-1:0]          weekday_i,
  input  logic signed [SensorW-1:0] sensor_reading_i,
  input  logic                      sensor_valid_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      fire_o,
  output logic                      conditions_met_o,
  output logic                      armed_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PaddrW-1:0]         paddr,
  input  logic [PdataW-1:0]         pwdata,
  output logic [PdataW-1:0]         prdata,
  output logic                      pready
);

  ste_cfg_t          cfg;
  ste_tick_t         tick_q;
  logic              tick_valid_q;
  logic              advance;
  logic              match;
  logic              active;
  logic              due;
  logic [TimeW-1:0]  elapsed;
  logic              fired_q, fired_d;
  logic [TimeW-1:0]  last_q, last_d;
  logic              fire_d, met_d;
  logic              out_valid_q;
  logic              fire_q, met_q, armed_q;

  ste_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ste_cond_match u_cond_match (
    .cfg_i   (cfg),
    .tick_i  (tick_q),
    .match_o (match)
  );

  assign advance    = tick_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = tick_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      tick_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      tick_q.mode           <= mode_i;
      tick_q.now_seconds    <= now_seconds_i;
      tick_q.minute_of_day  <= minute_of_day_i;
      tick_q.weekday        <= weekday_i;
      tick_q.sensor_reading <= sensor_reading_i;
      tick_q.sensor_valid   <= sensor_valid_i;
    end
  end

  assign active  = cfg.control_flags[FLAG_ACTIVE];
  assign elapsed = tick_q.now_seconds - last_q;
  assign due     = (cfg.refire_period != '0) &&
                   (elapsed >= {{(TimeW-RepeatW){1'b0}}, cfg.refire_period});

  always_comb begin
    fired_d = fired_q;
    last_d  = last_q;
    fire_d  = 1'b0;
    met_d   = 1'b0;
    case (tick_q.mode)
      MODE_CHECK: begin
        if (!active) begin
          fired_d = 1'b0;
        end else begin
          met_d = match;
          if (match && (!fired_q || due)) begin
            fire_d  = 1'b1;
            last_d  = tick_q.now_seconds;
            fired_d = 1'b1;
          end else if (!match) begin
            fired_d = 1'b0;
          end
        end
      end
      MODE_MANUAL: begin
        fire_d  = 1'b1;
        last_d  = tick_q.now_seconds;
        fired_d = 1'b1;
      end
      MODE_CLEAR: begin
        fired_d = 1'b0;
        last_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fired_q     <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        fired_q <= fired_d;
        last_q  <= last_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fire_q  <= fire_d;
      met_q   <= met_d;
      armed_q <= !fired_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign fire_o           = fire_q;
  assign conditions_met_o = met_q;
  assign armed_o          = armed_q;

endmodule

### rtl/ste_checker.sv
// Port-level checker of the schedule trigger evaluator and its bind.
module ste_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic fire_o,
  input logic conditions_met_o,
  input logic armed_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("tick stalled while result side free");

  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fire_o |-> !armed_o)
    else $error("armed after fire");

  a_met_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && conditions_met_o |-> !armed_o)
    else $error("armed while conditions met");

  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({fire_o, conditions_met_o, armed_o}))
    else $error("result word changed while stalled");

endmodule

bind schedule_trigger_evaluator ste_checker u_ste_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .fire_o           (fire_o),
  .conditions_met_o (conditions_met_o),
  .armed_o          (armed_o)
);

### dv/tb_schedule_trigger_evaluator.sv
// Self-checking testbench for the schedule trigger evaluator: random ticks, APB setup, checker.
module tb_schedule_trigger_evaluator import ste_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [1:0] CMP_NONE      = 2'd3;
  localparam logic [FlagsW-1:0] EN_EXACT   = FlagsW'(1 << FLAG_EXACT);
  localparam logic [FlagsW-1:0] EN_WINDOW  = FlagsW'(1 << FLAG_WINDOW);
  localparam logic [FlagsW-1:0] EN_WEEKDAY = FlagsW'(1 << FLAG_WEEKDAY);
  localparam logic [FlagsW-1:0] EN_SENSOR  = FlagsW'(1 << FLAG_SENSOR);
  localparam logic [FlagsW-1:0] EN_ACTIVE  = FlagsW'(1 << FLAG_ACTIVE);
  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 150;

  typedef struct packed {
    logic fire;
    logic conditions_met;
    logic armed;
  } trig_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                mode_i = '0;
  logic [TimeW-1:0]          now_seconds_i = '0;
  logic [MinuteW-1:0]        minute_of_day_i = '0;
  logic [WdayW-1:0]          weekday_i = '0;
  logic signed [SensorW-1:0] sensor_reading_i = '0;
  logic                      sensor_valid_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      fire_o;
  logic                      conditions_met_o;
  logic                      armed_o;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PaddrW-1:0]         paddr = '0;
  logic [PdataW-1:0]         pwdata = '0;
  logic [PdataW-1:0]         prdata;
  logic                      pready;

  ste_cfg_t          regs = '0;
  logic              trig_fired = 1'b0;
  logic [TimeW-1:0]  last_fire_s = '0;

  ste_tick_t         tick_queue[$];
  trig_result_t      predicted_results[$];
  ste_tick_t         cur_tick = '0;
  bit                busy = 1'b0;
  bit                in_took = 1'b0;
  bit                out_took = 1'b0;
  int                in_gap = 0;
  int                out_wait = 0;
  int                hold_left = 0;
  int                out_hold_req = 0;
  int                in_max_gap = 0;
  int                out_max_gap = 0;
  int                errors = 0;
  int                quiet = 0;

  logic [TimeW-1:0]          clock_base = '0;
  logic [MinuteW-1:0]        hold_minute = '0;
  logic [WdayW-1:0]          hold_wday = '0;
  logic signed [SensorW-1:0] hold_reading = '0;
  logic                      hold_valid = 1'b1;

  schedule_trigger_evaluator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .now_seconds_i    (now_seconds_i),
    .minute_of_day_i  (minute_of_day_i),
    .weekday_i        (weekday_i),
    .sensor_reading_i (sensor_reading_i),
    .sensor_valid_i   (sensor_valid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fire_o           (fire_o),
    .conditions_met_o (conditions_met_o),
    .armed_o          (armed_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic trig_result_t evaluate_trigger(input ste_tick_t t);
    trig_result_t     res;
    logic [3:0]       en;
    logic [7:0]       day_bits;
    logic [TimeW-1:0] elapsed;
    logic             met;
    logic             in_win;
    logic             sens_ok;
    logic             due;
    res = '0;
    en = regs.control_flags[3:0];
    day_bits = {1'b0, regs.weekday_mask};
    case (t.mode)
      MODE_CHECK: begin
        if (!regs.control_flags[FLAG_ACTIVE]) begin
          trig_fired = 1'b0;
        end else begin
          met = (en != 4'd0);
          if (en[FLAG_EXACT] && t.minute_of_day != regs.exact_minute) met = 1'b0;
          if (en[FLAG_WINDOW]) begin
            if (regs.window_start < regs.window_end) begin
              in_win = t.minute_of_day >= regs.window_start && t.minute_of_day < regs.window_end;
            end else begin
              in_win = t.minute_of_day >= regs.window_start || t.minute_of_day < regs.window_end;
            end
            if (!in_win) met = 1'b0;
          end
          if (en[FLAG_WEEKDAY] && !day_bits[t.weekday]) met = 1'b0;
          if (en[FLAG_SENSOR]) begin
            case (regs.sensor_compare)
              CMP_GT:  sens_ok = $signed(t.sensor_reading) > $signed(regs.sensor_threshold);
              CMP_LT:  sens_ok = $signed(t.sensor_reading) < $signed(regs.sensor_threshold);
              CMP_EQ:  sens_ok = t.sensor_reading == regs.sensor_threshold;
              default: sens_ok = 1'b0;
            endcase
            if (!t.sensor_valid || !sens_ok) met = 1'b0;
          end
          elapsed = t.now_seconds - last_fire_s;
          due = regs.refire_period != '0 && elapsed >= TimeW'(regs.refire_period);
          res.conditions_met = met;
          if (met && (!trig_fired || due)) begin
            res.fire = 1'b1;
            last_fire_s = t.now_seconds;
            trig_fired = 1'b1;
          end else if (!met) begin
            trig_fired = 1'b0;
          end
        end
      end
      MODE_MANUAL: begin
        res.fire = 1'b1;
        last_fire_s = t.now_seconds;
        trig_fired = 1'b1;
      end
      MODE_CLEAR: begin
        trig_fired = 1'b0;
        last_fire_s = '0;
      end
      default: ;
    endcase
    res.armed = !trig_fired;
    return res;
  endfunction

  task automatic report(input string what);
    $display("%0t ns: %s", $realtime, what);
    errors++;
  endtask

  // sample both channels; predict on every accepted tick, check every accepted result
  always @(posedge clk_i) begin : observe
    trig_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        predicted_results.push_back(evaluate_trigger(cur_tick));
      end
      if (out_valid_o && !out_stall_i) begin
        out_took = 1'b1;
        if (predicted_results.size() == 0) begin
          report("result word with no tick pending");
        end else begin
          want = predicted_results.pop_front();
          if (fire_o !== want.fire)
            report($sformatf("fire: want %b got %b", want.fire, fire_o));
          if (conditions_met_o !== want.conditions_met)
            report($sformatf("conditions_met: want %b got %b", want.conditions_met,
                             conditions_met_o));
          if (armed_o !== want.armed)
            report($sformatf("armed: want %b got %b", want.armed, armed_o));
        end
      end
    end
  end

  always @(negedge clk_i) begin : drive_ticks
    if (rst_ni) begin
      if (in_took) begin
        in_took = 1'b0;
        busy = 1'b0;
        in_gap = $urandom_range(0, in_max_gap);
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (tick_queue.size() > 0) begin
          cur_tick = tick_queue.pop_front();
          busy = 1'b1;
        end
      end
      in_valid_i       <= busy;
      mode_i           <= cur_tick.mode;
      now_seconds_i    <= cur_tick.now_seconds;
      minute_of_day_i  <= cur_tick.minute_of_day;
      weekday_i        <= cur_tick.weekday;
      sensor_reading_i <= cur_tick.sensor_reading;
      sensor_valid_i   <= cur_tick.sensor_valid;
    end
  end

  always @(negedge clk_i) begin : drive_stall
    if (out_hold_req > 0) begin
      hold_left = out_hold_req;
      out_hold_req = 0;
    end
    if (out_took) begin
      out_took = 1'b0;
      out_wait = $urandom_range(0, out_max_gap);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (out_wait > 0) || (hold_left > 0);
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [PdataW-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_CONTROL:   regs.control_flags = val[FlagsW-1:0];
      REG_EXACT:     regs.exact_minute = val[MinuteW-1:0];
      REG_WIN_START: regs.window_start = val[MinuteW-1:0];
      REG_WIN_END:   regs.window_end = val[MinuteW-1:0];
      REG_WDAY_MASK: regs.weekday_mask = val[WdayMaskW-1:0];
      REG_COMPARE:   regs.sensor_compare = val[1:0];
      REG_THRESHOLD: regs.sensor_threshold = val;
      REG_REPEAT:    regs.refire_period = val[RepeatW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [FlagsW-1:0] flags, input logic [MinuteW-1:0] exact,
                           input logic [MinuteW-1:0] ws, input logic [MinuteW-1:0] we,
                           input logic [WdayMaskW-1:0] mask, input logic [1:0] cmp,
                           input logic [31:0] thr, input logic [RepeatW-1:0] rpt);
    write_reg(REG_CONTROL, 32'(flags));
    write_reg(REG_EXACT, 32'(exact));
    write_reg(REG_WIN_START, 32'(ws));
    write_reg(REG_WIN_END, 32'(we));
    write_reg(REG_WDAY_MASK, 32'(mask));
    write_reg(REG_COMPARE, 32'(cmp));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_REPEAT, 32'(rpt));
  endtask

  // hold the sender until every predicted word has come back
  task automatic settle();
    while (tick_queue.size() != 0 || busy || predicted_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  function automatic ste_tick_t mk_tick(input logic [1:0] m, input logic [31:0] s,
                                        input logic [MinuteW-1:0] mi,
                                        input logic [WdayW-1:0] wd,
                                        input logic [31:0] rd, input logic v);
    ste_tick_t t;
    t.mode = m;
    t.now_seconds = s;
    t.minute_of_day = mi;
    t.weekday = wd;
    t.sensor_reading = rd;
    t.sensor_valid = v;
    return t;
  endfunction

  // mostly runs of similar ticks with a slowly advancing clock, so edges and re-fires occur
  function automatic ste_tick_t random_tick();
    ste_tick_t t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    t.mode = pick < 78 ? MODE_CHECK : pick < 86 ? MODE_MANUAL :
             pick < 94 ? MODE_CLEAR : MODE_RESERVED;
    pick = $urandom_range(0, 99);
    if (pick < 85) clock_base = clock_base + $urandom_range(0, 2 * regs.refire_period + 3);
    else if (pick < 95) clock_base = $urandom();
    else clock_base = clock_base - $urandom_range(1, 100);
    t.now_seconds = clock_base;
    if ($urandom_range(0, 9) < 3) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
        0: hold_minute = regs.window_start - 11'd1;
        1: hold_minute = regs.window_start;
        2: hold_minute = regs.window_end - 11'd1;
        3: hold_minute = regs.window_end;
        default: hold_minute = regs.exact_minute;
      endcase
      if (pick >= 55) hold_minute = pick < 92 ? MinuteW'($urandom_range(0, 1439)) :
                                                MinuteW'($urandom_range(1440, 2047));
      hold_wday = $urandom_range(0, 99) < 92 ? WdayW'($urandom_range(0, 6)) : 3'd7;
      pick = $urandom_range(0, 99);
      if (pick < 40) hold_reading = regs.sensor_threshold + 32'($urandom_range(0, 4)) - 32'd2;
      else if (pick < 50) hold_reading = regs.sensor_threshold;
      else if (pick < 80) hold_reading = $urandom();
      else if (pick < 87) hold_reading = 32'h8000_0000;
      else if (pick < 94) hold_reading = 32'h7FFF_FFFF;
      else hold_reading = '0;
      hold_valid = $urandom_range(0, 9) != 0;
    end
    t.minute_of_day = hold_minute;
    t.weekday = hold_wday;
    t.sensor_reading = hold_reading;
    t.sensor_valid = hold_valid;
    return t;
  endfunction

  initial begin
    int n;
    int pick;
    logic [31:0] thr;
    logic [MinuteW-1:0] ws;
    logic [MinuteW-1:0] we;
    logic [RepeatW-1:0] rpt;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    in_max_gap = 2;
    out_max_gap = 2;
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd0, 11'd0, 3'd0, 32'h8000_0000, 1'b0));
    tick_queue.push_back(mk_tick(MODE_MANUAL, 32'hFFFF_FFFF, 11'd2047, 3'd7, 32'h7FFF_FFFF,
                                 1'b1));
    tick_queue.push_back(mk_tick(MODE_RESERVED, 32'd5, 11'd1439, 3'd6, 32'd0, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd6, 11'd100, 3'd1, 32'd0, 1'b1));
    tick_queue.push_back(mk_tick(MODE_MANUAL, 32'd100, 11'd100, 3'd1, 32'd0, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CLEAR, 32'd101, 11'd100, 3'd1, 32'd0, 1'b1));
    settle();

    // wrapping window, weekend mask, reading above zero, re-fire every 5 s
    write_all(EN_ACTIVE | EN_WINDOW | EN_WEEKDAY | EN_SENSOR, 11'd0, 11'd1430, 11'd10,
              7'h41, CMP_GT, 32'd0, 24'd5);
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1000, 11'd1435, 3'd0, 32'd1, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1003, 11'd1435, 3'd0, 32'd1, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1005, 11'd1435, 3'd0, 32'd1, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1006, 11'd10, 3'd0, 32'd1, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1007, 11'd5, 3'd6, 32'd1, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1008, 11'd5, 3'd7, 32'd1, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1009, 11'd5, 3'd0, 32'd1, 1'b0));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1010, 11'd1430, 3'd0, 32'd0, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd1011, 11'd1430, 3'd0, 32'h7FFF_FFFF, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd900, 11'd1430, 3'd0, 32'h7FFF_FFFF, 1'b1));
    settle();

    write_all(EN_ACTIVE | EN_EXACT | EN_WINDOW | EN_SENSOR, 11'd1439, 11'd700, 11'd700,
              7'h00, CMP_NONE, 32'd0, 24'd0);
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd2000, 11'd1439, 3'd2, 32'd5, 1'b1));
    settle();
    write_reg(REG_COMPARE, 32'(CMP_LT));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd2001, 11'd1439, 3'd2, 32'h8000_0000, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd2002, 11'd2047, 3'd2, 32'h8000_0000, 1'b1));
    settle();
    write_all(EN_ACTIVE | EN_SENSOR, 11'd0, 11'd0, 11'd0, 7'h7F, CMP_EQ, 32'h7FFF_FFFF,
              24'hFF_FFFF);
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd10, 11'd3, 3'd3, 32'h7FFF_FFFF, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'h0100_0009, 11'd3, 3'd3, 32'h7FFF_FFFF, 1'b1));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'h0100_000A, 11'd3, 3'd3, 32'h7FFF_FFFF, 1'b1));
    settle();
    write_reg(REG_CONTROL, 32'(EN_ACTIVE));
    tick_queue.push_back(mk_tick(MODE_CHECK, 32'd11, 11'd3, 3'd3, 32'h7FFF_FFFF, 1'b1));

    for (int p = 0; p < 15; p++) begin
      settle();
      case (p)
        0: write_all('1, 11'd1439, 11'd1439, 11'd1439, 7'h7F, CMP_EQ, 32'h7FFF_FFFF,
                     24'hFF_FFFF);
        1: write_all(EN_ACTIVE, 11'd0, 11'd0, 11'd0, 7'h00, CMP_GT, 32'h8000_0000, 24'd0);
        default: begin
          ws = MinuteW'($urandom_range(0, 1439));
          we = $urandom_range(0, 4) == 0 ? ws : MinuteW'($urandom_range(0, 1439));
          pick = $urandom_range(0, 9);
          thr = pick < 7 ? $urandom() : pick < 8 ? 32'h8000_0000 :
                pick < 9 ? 32'h7FFF_FFFF : 32'd0;
          pick = $urandom_range(0, 19);
          rpt = pick < 12 ? RepeatW'($urandom_range(0, 10)) : pick < 17 ? '0 :
                RepeatW'($urandom_range(0, 24'hFF_FFFF));
          write_all(FlagsW'($urandom_range(0, 31)) | ($urandom_range(0, 4) != 0 ? EN_ACTIVE : '0),
                    MinuteW'($urandom_range(0, 1439)), ws, we,
                    WdayMaskW'($urandom_range(0, 127)), 2'($urandom_range(0, 3)), thr, rpt);
        end
      endcase
      if (p % 4 == 2) begin
        in_max_gap = 0;
        out_max_gap = 0;
      end else begin
        pick = $urandom_range(0, 2);
        in_max_gap = pick == 0 ? 0 : pick == 1 ? 3 : 13;
        pick = $urandom_range(0, 2);
        out_max_gap = pick == 0 ? 0 : pick == 1 ? 3 : 13;
      end
      if (p == 3) begin
        in_max_gap = 0;
        out_max_gap = 0;
        out_hold_req = HoldCycles;
      end
      n = $urandom_range(80, 110);
      repeat (n) tick_queue.push_back(random_tick());
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (predicted_results.size() != 0) report("ticks left without a result word");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### schedule_trigger_evaluator.f
rtl/ste_pkg.sv
rtl/ste_cfg_regs.sv
rtl/ste_cond_match.sv
rtl/schedule_trigger_evaluator.sv
rtl/ste_checker.sv
dv/tb_schedule_trigger_evaluator.sv
